[rtl/tdfa_pkg.sv]
package tdfa_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int IN_BITS        = 16;
    localparam int COUNT_BITS     = 3;
    localparam int LARGEST_BITS   = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

[rtl/trial_division_factor_analyzer_top.sv]
// Trial-division factor analyzer.
// Request channel: drive value and pulse start while busy is low; the request
// is taken at that edge and busy rises on the next cycle.
// Result channel: done is high for exactly one cycle with is_prime,
// distinct_prime_count and largest_prime_factor valid in that cycle. The
// receiver cannot stall; the result registers hold until the next result.
// Divisors d = 2, 3, ... are tried while d*d <= cofactor. Each trial
// division runs on one shared restoring divider, one quotient bit per
// cycle. Each factor divided out costs one more division. A 16-bit prime
// near 65535 takes 254 divisors. Values below 2 skip the trial loop: the
// request moves the state register straight to the finish step, which
// sets the registered done flag.
// Throughput: one request at a time; busy drops in the cycle that carries the
// result, so the next request can be taken at the end of that cycle.
// The running square d*d is kept by adding 2d+1, so no multiplier is used.
// Reset: asynchronous, active low; returns to idle with busy and done low.
module trial_division_factor_analyzer_top #(
    parameter int VALUE_BITS = tdfa_pkg::VALUE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [tdfa_pkg::IN_BITS-1:0]       value,
    output logic                               done,
    output logic                               is_prime,
    output logic [tdfa_pkg::COUNT_BITS-1:0]    distinct_prime_count,
    output logic [tdfa_pkg::LARGEST_BITS-1:0]  largest_prime_factor
);
    import tdfa_pkg::*;

    // trial divisor never exceeds about 2^(VALUE_BITS/2) + 1
    localparam int DW      = VALUE_BITS / 2 + 2;
    localparam int SQ_BITS = VALUE_BITS + 2;

    state_t state_reg, state_next;

    logic [VALUE_BITS-1:0]   rest_reg, rest_next;     // running cofactor
    logic [DW-1:0]           d_reg, d_next;           // trial divisor
    logic [SQ_BITS-1:0]      dsq_reg, dsq_next;       // d*d
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;       // saturating count
    logic [VALUE_BITS-1:0]   big_reg, big_next;       // largest factor so far
    logic                    divided_reg, divided_next;
    logic                    found_reg, found_next;   // d already counted
    logic                    low_reg, low_next;       // request value below 2

    logic                    done_reg, done_next;
    logic                    prime_reg, prime_next;
    logic [COUNT_BITS-1:0]   count_out_reg, count_out_next;
    logic [LARGEST_BITS-1:0] lpf_reg, lpf_next;

    logic [VALUE_BITS-1:0]   value_w;
    logic                    div_start;
    logic [VALUE_BITS-1:0]   div_dividend;
    logic                    div_done;
    logic [VALUE_BITS-1:0]   div_quo;
    logic [VALUE_BITS-1:0]   div_rem;
    logic                    sq_over;
    logic                    rest_gt1;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS-1:0] r;
        begin
            r = (c == '1) ? c : c + COUNT_BITS'(1);
            return r;
        end
    endfunction

    assign value_w  = VALUE_BITS'(value);
    assign sq_over  = (dsq_reg > SQ_BITS'(rest_reg));
    assign rest_gt1 = (rest_reg != VALUE_BITS'(1));

    // back-to-back divisions by the same d feed the fresh quotient straight in
    assign div_dividend = div_done ? div_quo : rest_reg;

    tdfa_div #(
        .WIDTH (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (VALUE_BITS'(d_reg)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = (value_w < VALUE_BITS'(2)) ? ST_FINISH : ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sq_over ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done && (div_rem != '0))
                    state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rest_next      = rest_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        cnt_next       = cnt_reg;
        big_next       = big_reg;
        divided_next   = divided_reg;
        found_next     = found_reg;
        low_next       = low_reg;
        prime_next     = prime_reg;
        count_out_next = count_out_reg;
        lpf_next       = lpf_reg;
        done_next      = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rest_next    = value_w;
                    d_next       = DW'(2);
                    dsq_next     = SQ_BITS'(4);
                    cnt_next     = '0;
                    big_next     = '0;
                    divided_next = 1'b0;
                    found_next   = 1'b0;
                    low_next     = (value_w < VALUE_BITS'(2));
                end
            end
            ST_CHECK:
            begin
                if (!sq_over)
                    div_start = 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        // divide this factor out again
                        rest_next = div_quo;
                        div_start = 1'b1;
                        if (!found_reg)
                        begin
                            cnt_next     = sat_inc(cnt_reg);
                            big_next     = VALUE_BITS'(d_reg);
                            divided_next = 1'b1;
                            found_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + DW'(1);
                        dsq_next   = dsq_reg + SQ_BITS'({d_reg, 1'b1});
                        found_next = 1'b0;
                    end
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                if (low_reg)
                begin
                    prime_next     = 1'b0;
                    count_out_next = '0;
                    lpf_next       = '0;
                end
                else
                begin
                    prime_next     = !divided_reg;
                    count_out_next = rest_gt1 ? sat_inc(cnt_reg) : cnt_reg;
                    lpf_next       = rest_gt1 ? LARGEST_BITS'(rest_reg)
                                              : LARGEST_BITS'(big_reg);
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            prime_reg     <= 1'b0;
            count_out_reg <= '0;
            lpf_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            prime_reg     <= prime_next;
            count_out_reg <= count_out_next;
            lpf_reg       <= lpf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        d_reg       <= d_next;
        dsq_reg     <= dsq_next;
        cnt_reg     <= cnt_next;
        big_reg     <= big_next;
        divided_reg <= divided_next;
        found_reg   <= found_next;
        low_reg     <= low_next;
    end

    assign busy                 = (state_reg != ST_IDLE);
    assign done                 = done_reg;
    assign is_prime             = prime_reg;
    assign distinct_prime_count = count_out_reg;
    assign largest_prime_factor = lpf_reg;

    // result strobe only comes out right after the finish step
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_IDLE) && ($past(state_reg) == ST_FINISH))
        else $error("done without a finish step");

    // an accepted request makes the block busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // divider is only kicked from the check or divide steps
    a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> ((state_reg == ST_CHECK) || (state_reg == ST_DIV)))
        else $error("divider started outside the trial loop");

    // a prime has exactly one distinct factor
    a_prime_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_prime) |-> (distinct_prime_count == COUNT_BITS'(1)))
        else $error("prime reported with a factor count other than one");

    // divider must report back before the trial loop moves on
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && !div_done) |=> (state_reg == ST_DIV))
        else $error("left divide step before the divider finished");

endmodule

[rtl/tdfa_div.sv]
module tdfa_div #(
    parameter int WIDTH = tdfa_pkg::VALUE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [WIDTH:0]   trial;
    logic             fits;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[WIDTH-1]};
        diff     = trial - {1'b0, divisor};
        fits     = (trial >= {1'b0, divisor});
        rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
                cnt_reg <= CW'(WIDTH);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[tb/trial_division_factor_analyzer_top_tb.sv]
module trial_division_factor_analyzer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tdfa_pkg::*;

    // Run shape. The stall limit leaves a wide margin over one full
    // factorization of the worst request (a 16-bit prime) plus the longest
    // request gap.
    localparam int RANDOM_REQUESTS = 118;
    localparam int STALL_LIMIT     = 40000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_GAP         = 40;
    // Window of random requests sent back to back, with no idle cycles at all.
    localparam int QUIET_FIRST     = 40;
    localparam int QUIET_LAST      = 80;

    localparam int SMALL_PRIMES [8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    // Primes just under 256: their squares sit right on the d*d <= cofactor bound.
    localparam int EDGE_PRIMES  [6] = '{227, 229, 233, 239, 241, 251};

    // Directed requests: both ends of the range, the below-two cases, small
    // primes, prime powers, the six-factor value, the largest 16-bit prime,
    // squares of primes and alternating bit patterns.
    localparam logic [IN_BITS-1:0] DIRECTED_VALUES [22] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd49,
        16'd30030,   // 2*3*5*7*11*13, six distinct factors
        16'd65535,   // 3*5*17*257
        16'd65521,   // largest 16-bit prime
        16'd65534,   // 2*7*31*151
        16'd32768,   // 2^15
        16'd65025,   // 3^2*5^2*17^2
        16'd63001,   // 251^2
        16'd64009,   // 253^2 = 11^2*23^2
        16'd32749,   // prime
        16'd57121,   // 239^2
        16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'hFFFE
    };

    typedef struct packed {
        logic                    is_prime;
        logic [COUNT_BITS-1:0]   count;
        logic [LARGEST_BITS-1:0] largest;
    } factor_t;

    typedef struct {
        logic [IN_BITS-1:0] value;
        factor_t            want;
    } factor_request_t;

    // Holds the expected factorization of every accepted request, in order,
    // and checks each done strobe against the oldest one.
    class factor_scoreboard;
        factor_request_t waiting[$];
        int              errors = 0;

        // Trial division exactly as the block defines it: every divisor that
        // divides the cofactor is removed fully and counted once; a leftover
        // cofactor above 1 is the last and largest factor.
        function factor_t factor_value(input logic [IN_BITS-1:0] v);
            factor_t     r;
            int unsigned rest;
            int unsigned d;
            int unsigned cnt;
            int unsigned big;
            logic        split;
            r     = '0;
            rest  = 32'(v);
            cnt   = 0;
            big   = 0;
            split = 1'b0;
            if (v < 2)
                return r;
            for (d = 2; d * d <= rest; d++)
            begin
                if (rest % d == 0)
                begin
                    while (rest % d == 0)
                        rest = rest / d;
                    cnt++;
                    big   = d;
                    split = 1'b1;
                end
            end
            if (rest != 1)
            begin
                cnt++;
                big = rest;
            end
            r.is_prime = !split;
            r.count    = (cnt > 7) ? 3'd7 : cnt[COUNT_BITS-1:0];
            r.largest  = big[LARGEST_BITS-1:0];
            return r;
        endfunction

        function void note_request(input logic [IN_BITS-1:0] v);
            factor_request_t e;
            e.value = v;
            e.want  = factor_value(v);
            waiting.push_back(e);
        endfunction

        function void check_result(input logic                    got_prime,
                                   input logic [COUNT_BITS-1:0]   got_count,
                                   input logic [LARGEST_BITS-1:0] got_largest);
            factor_request_t e;
            if (waiting.size() == 0)
            begin
                $display("%0t: unexpected result, is_prime=%0b count=%0d largest=%0d",
                         $time, got_prime, got_count, got_largest);
                errors++;
                return;
            end
            e = waiting.pop_front();
            if (got_prime !== e.want.is_prime)
            begin
                $display("%0t: value %0d is_prime expected %0b actual %0b",
                         $time, e.value, e.want.is_prime, got_prime);
                errors++;
            end
            if (got_count !== e.want.count)
            begin
                $display("%0t: value %0d distinct_prime_count expected %0d actual %0d",
                         $time, e.value, e.want.count, got_count);
                errors++;
            end
            if (got_largest !== e.want.largest)
            begin
                $display("%0t: value %0d largest_prime_factor expected %0d actual %0d",
                         $time, e.value, e.want.largest, got_largest);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [IN_BITS-1:0]      value = '0;
    logic                    busy;
    logic                    done;
    logic                    is_prime;
    logic [COUNT_BITS-1:0]   distinct_prime_count;
    logic [LARGEST_BITS-1:0] largest_prime_factor;

    factor_scoreboard sb = new;
    int               idle_cycles = 0;

    trial_division_factor_analyzer_top dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .value                (value),
        .done                 (done),
        .is_prime             (is_prime),
        .distinct_prime_count (distinct_prime_count),
        .largest_prime_factor (largest_prime_factor)
    );

    always #2 clk = ~clk;

    // Monitor: samples pre-edge values, so the drivers' nonblocking updates at
    // the same edge never race with it. Also runs the stall watchdog, which
    // restarts on every accepted request and every result.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(value);
        if (rst_n && done)
            sb.check_result(is_prime, distinct_prime_count, largest_prime_factor);
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Holds start high with the value until the block takes the request.
    // Called at a rising edge; returns at the edge that accepted it.
    task automatic send_value(input logic [IN_BITS-1:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender idling after a request: about 15 in 100, none in the quiet window.
    // Gap lengths are spread so some end while the block is mid-division and
    // some run past the result.
    task automatic idle_after(input int idx);
        int gap;
        gap = 0;
        if ((idx < QUIET_FIRST || idx > QUIET_LAST) && $urandom_range(0, 99) < 15)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random value mix: plain uniform words for bit coverage, plus small values,
    // smooth products with many distinct factors, prime powers, the top of
    // the range and squares of primes near 256.
    function automatic logic [IN_BITS-1:0] pick_value();
        int unsigned prod;
        int unsigned p;
        prod = 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: prod = $urandom_range(0, 65535);
            4:          prod = $urandom_range(0, 300);
            5, 6:
            begin
                repeat ($urandom_range(2, 10))
                begin
                    p = SMALL_PRIMES[$urandom_range(0, 7)];
                    if (prod * p <= 65535)
                        prod = prod * p;
                end
            end
            7:
            begin
                p    = SMALL_PRIMES[$urandom_range(0, 7)];
                prod = p;
                while (prod * p <= 65535 && $urandom_range(0, 3) != 0)
                    prod = prod * p;
            end
            8:       prod = $urandom_range(65000, 65535);
            default:
            begin
                p    = EDGE_PRIMES[$urandom_range(0, 5)];
                prod = p * p;
            end
        endcase
        return prod[IN_BITS-1:0];
    endfunction

    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_VALUES[k])
        begin
            send_value(DIRECTED_VALUES[k]);
            idle_after(QUIET_LAST + 1);
        end

        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            send_value(pick_value());
            idle_after(i);
        end
        start <= 1'b0;
        // let the monitor log the last accepted request before the queue is read
        @(posedge clk);

        // No result can come without a pending request, so once the queue is
        // empty only a short settle is needed before the verdict.
        while (sb.waiting.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.waiting.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/tdfa_pkg.sv
rtl/tdfa_div.sv
rtl/trial_division_factor_analyzer_top.sv
tb/trial_division_factor_analyzer_top_tb.sv
